>>> rtl/gsa_pkg.sv
package gsa_pkg;

    localparam int SLOTS_DEFAULT = 256;

    localparam int KIND_W   = 3;
    localparam int IDX_W    = 8;
    localparam int GEN_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 9;
    localparam int LIVE_W   = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [KIND_W-1:0] KIND_ALLOC    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET_FLAG = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GET_FLAG = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_POP,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic             alive;
        logic             flag;
        logic [GEN_W-1:0] gen;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic stack_rd;
        logic tab_rd;
        logic tab_from_stack;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic is_alloc;
        logic stack_nonempty;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/gsa_controller.sv
module gsa_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gsa_pkg::t_stat i_stat,
    output gsa_pkg::t_cmd  o_cmd
);
    import gsa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.tab_rd = 1'b1;
                if (i_stat.is_alloc && i_stat.stack_nonempty) begin
                    o_cmd.stack_rd = 1'b1;
                    n_state        = S_POP;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_POP: begin
                o_cmd.tab_rd         = 1'b1;
                o_cmd.tab_from_stack = 1'b1;
                n_state              = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_to_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_FETCH))
        else $error("accepted item did not start a lookup");

    a_exec_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> i_stat.out_free)
        else $error("result issued while output register is occupied");

    a_pop_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> ($past(r_state) == S_FETCH))
        else $error("stack pop not preceded by fetch");

endmodule

>>> rtl/gsa_datapath.sv
module gsa_datapath #(
    parameter int SLOTS = gsa_pkg::SLOTS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [gsa_pkg::CAP_W-1:0]     i_cfg_wr_data,
    input  logic [gsa_pkg::KIND_W-1:0]    i_kind,
    input  logic [gsa_pkg::IDX_W-1:0]     i_handle_index,
    input  logic [gsa_pkg::GEN_W-1:0]     i_handle_generation,
    input  logic                          i_flag_value,
    input  gsa_pkg::t_cmd                 i_cmd,
    output gsa_pkg::t_stat                o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gsa_pkg::STATUS_W-1:0]  o_status,
    output logic [gsa_pkg::IDX_W-1:0]     o_slot_index,
    output logic [gsa_pkg::GEN_W-1:0]     o_slot_generation,
    output logic                          o_answer_bit,
    output logic [gsa_pkg::LIVE_W-1:0]    o_live_count
);
    import gsa_pkg::*;

    localparam int AW    = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int SUM_W = CNT_W + 1;

    t_entry            r_table [SLOTS];
    logic [AW-1:0]     r_stack [SLOTS];

    logic [KIND_W-1:0] r_kind;
    logic [IDX_W-1:0]  r_idx;
    logic [GEN_W-1:0]  r_gen;
    logic              r_flag;
    logic [CAP_W-1:0]  r_capacity;
    logic [CNT_W-1:0]  r_depth;
    logic [CNT_W-1:0]  r_hw;
    logic [CNT_W-1:0]  r_alive;
    logic [AW-1:0]     r_stack_q;
    t_entry            r_tab_q;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [IDX_W-1:0]    r_out_index;
    logic [GEN_W-1:0]    r_out_gen;
    logic                r_out_answer;
    logic [LIVE_W-1:0]   r_out_live;

    logic [CNT_W-1:0]    n_depth;
    logic [CNT_W-1:0]    n_hw;
    logic [CNT_W-1:0]    n_alive;

    logic [CNT_W-1:0]    depth_m1;
    logic [AW-1:0]       tab_addr;
    logic [CMP_W-1:0]    cap_eff;
    logic                from_stack;
    logic                got;
    logic [AW-1:0]       alloc_slot;
    logic [GEN_W-1:0]    alloc_gen;
    logic                handle_ok;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_entry              wr_data;
    logic                push;
    logic [STATUS_W-1:0] res_status;
    logic [IDX_W-1:0]    res_index;
    logic [GEN_W-1:0]    res_gen;
    logic                res_answer;

    assign depth_m1 = r_depth - CNT_W'(1);
    assign tab_addr = i_cmd.tab_from_stack ? r_stack_q : AW'(r_idx);

    assign o_stat.is_alloc       = (r_kind == KIND_ALLOC);
    assign o_stat.stack_nonempty = (r_depth != '0);
    assign o_stat.out_free       = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_idx  <= i_handle_index;
            r_gen  <= i_handle_generation;
            r_flag <= i_flag_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stack_rd) begin
            r_stack_q <= r_stack[depth_m1[AW-1:0]];
        end
        if (i_cmd.exec && push) begin
            r_stack[r_depth[AW-1:0]] <= AW'(r_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tab_rd) begin
            r_tab_q <= r_table[tab_addr];
        end
        if (i_cmd.exec && wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        cap_eff    = (CMP_W'(r_capacity) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS)
                                                           : CMP_W'(r_capacity);
        from_stack = (r_depth != '0);
        got        = from_stack || (CMP_W'(r_hw) < cap_eff);
        alloc_slot = from_stack ? r_stack_q : AW'(r_hw);
        alloc_gen  = (from_stack ? r_tab_q.gen : '0) + GEN_W'(1);
        handle_ok  = (r_gen != '0) && (CMP_W'(r_idx) < CMP_W'(r_hw)) &&
                     r_tab_q.alive && (r_tab_q.gen == r_gen);

        n_depth    = r_depth;
        n_hw       = r_hw;
        n_alive    = r_alive;
        wr_en      = 1'b0;
        wr_addr    = AW'(r_idx);
        wr_data    = r_tab_q;
        push       = 1'b0;
        res_status = STATUS_OK;
        res_index  = r_idx;
        res_gen    = '0;
        res_answer = 1'b0;

        unique case (r_kind)
            KIND_ALLOC: begin
                if (got) begin
                    if (from_stack) begin
                        n_depth = depth_m1;
                    end else begin
                        n_hw = r_hw + CNT_W'(1);
                    end
                    n_alive       = r_alive + CNT_W'(1);
                    wr_en         = 1'b1;
                    wr_addr       = alloc_slot;
                    wr_data.alive = 1'b1;
                    wr_data.flag  = 1'b0;
                    wr_data.gen   = alloc_gen;
                    res_index     = IDX_W'(alloc_slot);
                    res_gen       = alloc_gen;
                end else begin
                    res_status = STATUS_FULL;
                    res_index  = '0;
                end
            end
            KIND_RELEASE: begin
                if (handle_ok) begin
                    wr_en         = 1'b1;
                    wr_data.alive = 1'b0;
                    push          = 1'b1;
                    n_depth       = r_depth + CNT_W'(1);
                    n_alive       = r_alive - CNT_W'(1);
                end else begin
                    res_status = STATUS_INVALID;
                end
            end
            KIND_CHECK: begin
                if (handle_ok) begin
                    res_answer = 1'b1;
                end else begin
                    res_status = STATUS_INVALID;
                end
            end
            KIND_SET_FLAG: begin
                if (handle_ok) begin
                    wr_en        = 1'b1;
                    wr_data.flag = r_flag;
                end else begin
                    res_status = STATUS_INVALID;
                end
            end
            KIND_GET_FLAG: begin
                if (handle_ok) begin
                    res_answer = r_tab_q.flag;
                end else begin
                    res_status = STATUS_INVALID;
                end
            end
            default: begin
                res_status = STATUS_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_depth     <= '0;
            r_hw        <= '0;
            r_alive     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                r_depth     <= n_depth;
                r_hw        <= n_hw;
                r_alive     <= n_alive;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status <= res_status;
            r_out_index  <= res_index;
            r_out_gen    <= res_gen;
            r_out_answer <= res_answer;
            r_out_live   <= LIVE_W'(n_alive);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_slot_index      = r_out_index;
    assign o_slot_generation = r_out_gen;
    assign o_answer_bit      = r_out_answer;
    assign o_live_count      = r_out_live;

    a_slots_accounted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SUM_W'(r_alive) + SUM_W'(r_depth)) == SUM_W'(r_hw))
        else $error("live plus free slots differ from high-water mark");

    a_hw_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_hw) <= CMP_W'(SLOTS))
        else $error("high-water mark beyond table size");

    a_full_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == STATUS_FULL)) |->
        ((r_out_gen == '0) && (r_out_index == '0) && !r_out_answer))
        else $error("full result carries slot data");

endmodule

>>> rtl/generational_slot_allocator_core.sv
// Steps: an accepted item is captured in S_IDLE, S_FETCH reads the slot table, and S_EXEC issues
// the result; an allocate that pops the free stack reads the stack top in S_FETCH and its slot in
// S_POP. The single-port slot table is read, then modified and written. One item is in flight
// at a time, and an item holds in its last step while the previous result waits to be accepted.
// Reset: counters, free-stack depth and high-water mark clear, capacity returns to 256, no result
// pending. Slot memories are not swept; slots above the high-water mark are treated as zero.
module generational_slot_allocator_core #(
    parameter int SLOTS = gsa_pkg::SLOTS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [gsa_pkg::CAP_W-1:0]     i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [gsa_pkg::KIND_W-1:0]    i_kind,
    input  logic [gsa_pkg::IDX_W-1:0]     i_handle_index,
    input  logic [gsa_pkg::GEN_W-1:0]     i_handle_generation,
    input  logic                          i_flag_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gsa_pkg::STATUS_W-1:0]  o_status,
    output logic [gsa_pkg::IDX_W-1:0]     o_slot_index,
    output logic [gsa_pkg::GEN_W-1:0]     o_slot_generation,
    output logic                          o_answer_bit,
    output logic [gsa_pkg::LIVE_W-1:0]    o_live_count
);
    import gsa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    gsa_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gsa_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_kind              (i_kind),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .i_flag_value        (i_flag_value),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_slot_index        (o_slot_index),
        .o_slot_generation   (o_slot_generation),
        .o_answer_bit        (o_answer_bit),
        .o_live_count        (o_live_count)
    );

endmodule
